// File: rtl/core/sacd_pkg.sv
// Shared types and constants for the SACD audio sector packet parser.
// Used by the result and cfg interfaces, front, job queue, back and top level.
`default_nettype none
package sacd_pkg;

    localparam int MAX_PACKETS = 7;
    localparam int IDX_W       = 3;
    localparam int LEN_W       = 11;
    localparam int OFF_W       = 13;
    localparam int TYPE_W      = 3;
    localparam int FIRST_W     = 6;

    localparam logic [OFF_W-1:0] SECTOR_SIZE_RESET = 13'd2048;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic              frame_begin;
        logic [TYPE_W-1:0] pkt_type;
        logic [LEN_W-1:0]  payload_len;
        logic [OFF_W-1:0]  packet_offset;
    } desc_t;

    // count of zero marks a single flag result carrying status
    typedef struct packed {
        logic                         status;
        logic [IDX_W-1:0]             count;
        desc_t [MAX_PACKETS-1:0]      desc;
    } job_t;

endpackage
`default_nettype wire

// File: rtl/core/sacd_byte_if.sv
// Input byte channel of the SACD sector parser.
// Depends on nothing beyond the clock domain of its users.
`default_nettype none
interface sacd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       sector_start;

    modport source (output valid, output data_byte, output sector_start, input ready);
    modport sink   (input valid, input data_byte, input sector_start, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sacd_result_if.sv
// Result channel of the SACD sector parser.
// Field widths come from sacd_pkg.
`default_nettype none
interface sacd_result_if;
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic                            has_packet;
    logic [sacd_pkg::IDX_W-1:0]      packet_index;
    logic                            frame_begin;
    logic [sacd_pkg::TYPE_W-1:0]     pkt_type;
    logic [sacd_pkg::LEN_W-1:0]      payload_len;
    logic [sacd_pkg::OFF_W-1:0]      packet_offset;
    logic                            last;

    modport source (output valid, output status, output has_packet, output packet_index,
                    output frame_begin, output pkt_type, output payload_len,
                    output packet_offset, output last, input ready);
    modport sink   (input valid, input status, input has_packet, input packet_index,
                    input frame_begin, input pkt_type, input payload_len,
                    input packet_offset, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sacd_cfg_if.sv
// Configuration write channel carrying the sector size register.
// Width comes from sacd_pkg.
`default_nettype none
interface sacd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sacd_pkg::OFF_W-1:0]  sector_size;

    modport source (output valid, output sector_size, input ready);
    modport sink   (input valid, input sector_size, output ready);
endinterface
`default_nettype wire

// File: rtl/core/sacd_front.sv
// Front end: accepts sector bytes, decodes the header and packet-info table,
// and pushes one finished job per sector into the job queue. Uses sacd_pkg.
`default_nettype none
module sacd_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    sacd_byte_if.sink                        bytes,
    input  wire logic [sacd_pkg::OFF_W-1:0]  sector_size,
    input  wire logic                        queue_full,
    output      logic                        job_push,
    output      sacd_pkg::job_t              job
);

    typedef enum logic [0:0] {
        PH_IDLE,
        PH_TABLE
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic [sacd_pkg::IDX_W-1:0]        pkts_reg, pkts_next;
    logic [3:0]                        seen_reg, seen_next;
    logic [7:0]                        hi_reg, hi_next;
    logic [sacd_pkg::OFF_W-1:0]        off_reg, off_next;
    logic                              ovr_reg, ovr_next;
    sacd_pkg::desc_t [sacd_pkg::MAX_PACKETS-1:0] desc_reg, desc_next;

    logic                              fire;
    logic [2:0]                        pc, fc;
    logic [2:0]                        fsize;
    logic [sacd_pkg::FIRST_W-1:0]      first;
    logic [sacd_pkg::IDX_W-1:0]        idx;
    logic [sacd_pkg::LEN_W-1:0]        len;
    logic [sacd_pkg::OFF_W:0]          sum;

    assign bytes.ready = !queue_full;
    assign fire        = bytes.valid && !queue_full;

    assign pc    = bytes.data_byte[7:5];
    assign fc    = bytes.data_byte[4:2];
    assign fsize = bytes.data_byte[0] ? 3'd4 : 3'd3;
    assign first = 6'd1 + {2'b00, pc, 1'b0} + (6'(fc) * 6'(fsize));
    assign idx   = seen_reg[3:1];
    assign len   = {hi_reg[2:0], bytes.data_byte};
    assign sum   = {1'b0, off_reg} + 14'(len);

    always_comb
    begin
        phase_next = phase_reg;
        pkts_next  = pkts_reg;
        seen_next  = seen_reg;
        hi_next    = hi_reg;
        off_next   = off_reg;
        ovr_next   = ovr_reg;
        desc_next  = desc_reg;
        job_push   = 1'b0;
        job.status = sacd_pkg::STATUS_OK;
        job.count  = '0;
        if (fire)
        begin
            if (bytes.sector_start)
            begin
                // a start flag drops whatever table was in progress
                phase_next = PH_IDLE;
                if (sector_size == '0 || 13'(first) > sector_size)
                begin
                    job_push   = 1'b1;
                    job.status = sacd_pkg::STATUS_REJECT;
                end
                else if (pc == '0)
                begin
                    job_push = 1'b1;
                end
                else
                begin
                    phase_next = PH_TABLE;
                    pkts_next  = pc;
                    seen_next  = '0;
                    hi_next    = '0;
                    off_next   = 13'(first);
                    ovr_next   = 1'b0;
                end
            end
            else if (phase_reg == PH_TABLE)
            begin
                seen_next = seen_reg + 4'd1;
                if (!seen_reg[0])
                begin
                    hi_next = bytes.data_byte;
                end
                else
                begin
                    if (!ovr_reg)
                    begin
                        if (sum > {1'b0, sector_size})
                        begin
                            ovr_next = 1'b1;
                        end
                        else
                        begin
                            desc_next[idx].frame_begin   = hi_reg[7];
                            desc_next[idx].pkt_type      = hi_reg[5:3];
                            desc_next[idx].payload_len   = len;
                            desc_next[idx].packet_offset = off_reg;
                            off_next                     = sum[sacd_pkg::OFF_W-1:0];
                        end
                    end
                    if ({1'b0, idx} + 4'd1 >= {1'b0, pkts_reg})
                    begin
                        phase_next = PH_IDLE;
                        job_push   = 1'b1;
                        if (ovr_next)
                        begin
                            job.status = sacd_pkg::STATUS_REJECT;
                        end
                        else
                        begin
                            job.count = pkts_reg;
                        end
                    end
                end
            end
        end
        job.desc = desc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pkts_reg  <= '0;
            seen_reg  <= '0;
            hi_reg    <= '0;
            off_reg   <= '0;
            ovr_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pkts_reg  <= pkts_next;
            seen_reg  <= seen_next;
            hi_reg    <= hi_next;
            off_reg   <= off_next;
            ovr_reg   <= ovr_next;
        end
    end

    // descriptor buffer: read only after written within the same sector
    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule
`default_nettype wire

// File: rtl/core/sacd_job_fifo.sv
// Two-entry job queue between the parser front and the result back end.
// Uses sacd_pkg::job_t.
`default_nettype none
module sacd_job_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sacd_pkg::job_t  push_job,
    input  wire logic            pop,
    output      logic            full,
    output      logic            empty,
    output      sacd_pkg::job_t  head
);

    sacd_pkg::job_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sacd_back.sv
// Back end: takes one job at a time from the queue and plays it out as a
// run of result requests. Uses sacd_pkg and sacd_result_if.
`default_nettype none
module sacd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    input  wire sacd_pkg::job_t  job_head,
    output      logic            job_pop,
    sacd_result_if.source        results
);

    logic                        busy_reg, busy_next;
    logic [sacd_pkg::IDX_W-1:0]  k_reg, k_next;
    sacd_pkg::job_t              job_reg;
    logic                        fire, is_last;
    sacd_pkg::desc_t             cur;

    assign cur     = job_reg.desc[k_reg];
    assign is_last = (job_reg.count == '0) || (3'(k_reg + 3'd1) == job_reg.count);
    assign fire    = busy_reg && results.ready;
    assign job_pop = job_valid && (!busy_reg || (fire && is_last));

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (fire)
        begin
            k_next = k_reg + 3'd1;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (job_pop)
        begin
            busy_next = 1'b1;
            k_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job_head;
        end
    end

    always_comb
    begin
        results.valid = busy_reg;
        results.last  = is_last;
        if (job_reg.count == '0)
        begin
            results.status        = job_reg.status;
            results.has_packet    = 1'b0;
            results.packet_index  = '0;
            results.frame_begin   = 1'b0;
            results.pkt_type      = '0;
            results.payload_len   = '0;
            results.packet_offset = '0;
        end
        else
        begin
            results.status        = sacd_pkg::STATUS_OK;
            results.has_packet    = 1'b1;
            results.packet_index  = k_reg;
            results.frame_begin   = cur.frame_begin;
            results.pkt_type      = cur.pkt_type;
            results.payload_len   = cur.payload_len;
            results.packet_offset = cur.packet_offset;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sacd_audio_sector_packet_parse_unit.sv
// SACD audio sector packet parser, top level.
// Channels: bytes (one sector byte per request, sector_start on the header
// byte), results (packet descriptors or a single flag result), cfg (writes
// the sector size register; always ready, to be written only while idle).
// Throughput: one byte per cycle on bytes unless the job queue is full; a
// sector's run of n descriptors leaves at one result per cycle while
// results is ready. A two-entry job queue sits between the parsing front
// and the result back end. With the back end idle, the first result of a
// sector is valid once the job for the byte completing the table (or the
// header byte for a flag result) is stored in the queue, then in the back end.
// When results stalls, the back end holds the sector it is playing out and
// the queue up to two more; once both slots are taken bytes.ready drops
// until the back end frees one.
// Reset: parser idle, queue empty, no result valid, sector size 2048.
// Bytes outside a table are dropped; a start flag restarts parsing at once.
`default_nettype none
module sacd_audio_sector_packet_parse_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    sacd_byte_if.sink       bytes,
    sacd_result_if.source   results,
    sacd_cfg_if.sink        cfg
);

    logic [sacd_pkg::OFF_W-1:0] sector_size_reg;
    logic                       job_push, job_pop, q_full, q_empty;
    sacd_pkg::job_t             job_in, job_head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_size_reg <= sacd_pkg::SECTOR_SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            sector_size_reg <= cfg.sector_size;
        end
    end

    sacd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (bytes),
        .sector_size (sector_size_reg),
        .queue_full  (q_full),
        .job_push    (job_push),
        .job         (job_in)
    );

    sacd_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job_in),
        .pop      (job_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (job_head)
    );

    sacd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .results   (results)
    );

    // a job is never offered while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("job offered to full queue");

    // descriptors within a run follow each other in table order
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.has_packet && !results.last)
        |=> (results.valid && results.has_packet
             && results.packet_index == 3'($past(results.packet_index) + 3'd1)))
        else $error("descriptor run out of order");

    // every reported packet ends inside the sector
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.has_packet)
        |-> (({1'b0, results.packet_offset} + 14'(results.payload_len))
             <= {1'b0, sector_size_reg}) && (results.status == sacd_pkg::STATUS_OK))
        else $error("packet past sector end reported");

endmodule
`default_nettype wire
